FILE: sv/gdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gdfs_pkg
// Shared types and codes for the grid depth-first search step engine.
// ---------------------------------------------------------------------------
package gdfs_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;
  localparam logic [1:0] REQ_STEP  = 2'd3;

  // Cell codes.
  localparam logic [2:0] CODE_EMPTY   = 3'd0;
  localparam logic [2:0] CODE_WALL    = 3'd1;
  localparam logic [2:0] CODE_START   = 3'd2;
  localparam logic [2:0] CODE_END     = 3'd3;
  localparam logic [2:0] CODE_QUEUED  = 3'd4;
  localparam logic [2:0] CODE_VISITED = 3'd5;

  // Register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [2:0] cell_code;
  } req_t;

  typedef struct packed {
    logic [2:0] read_code;
    logic       finished;
    logic       found_end;
    logic [5:0] popped_x;
    logic [5:0] popped_y;
    logic       overflow;
  } rsp_t;

endpackage
`default_nettype wire

FILE: sv/gdfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gdfs_ram
// Single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module gdfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle; read data shows in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

FILE: sv/grid_depth_first_search_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grid_depth_first_search_step
// Depth-first search over a grid of cell codes held in RAM, with a
// coordinate stack in a second RAM.
//
//   channel  dir  handshake              payload
//   req      in   req_valid_i/req_ready_o  req_i   (gdfs_pkg::req_t)
//   rsp      out  rsp_valid_o/rsp_ready_i  rsp_o   (gdfs_pkg::rsp_t)
//   cfg      in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Write and read pass through the RD, RDW and DONE states before the
// result is valid; a step pops the stack, reads the popped cell and then
// each neighbour in turn, all through the single grid RAM port. Init
// reads the grid cell by cell in SCAN and SCANW up to the start cell.
// After reset a clearing pass writes every grid cell to empty, one a cycle;
// requests wait for it. One request is in flight at a time; the next is
// taken once its result has left the output register.
// ---------------------------------------------------------------------------
module grid_depth_first_search_step #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire gdfs_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_ready_i,
  output gdfs_pkg::rsp_t       rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [6:0]      cfg_data_i
);
  import gdfs_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int GD = MAX_WIDTH * MAX_HEIGHT;
  localparam int GA = $clog2(GD);
  localparam int SA = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  // Coordinates carry one extra bit so that x+1 at the edge stays visible.
  localparam int XC = XW + 1;
  localparam int YC = YW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_RDW, S_DONE,
    S_SCAN, S_SCANW, S_POP, S_POPW, S_CUR, S_NB, S_NBW, S_NBCHK, S_PUSH
  } state_e;

  state_e state_q;
  logic [6:0] width_q, height_q;
  logic [XC-1:0] cx_q, nx_q;
  logic [YC-1:0] cy_q, ny_q;
  logic [1:0] nb_q;
  logic [CW-1:0] cnt_q;
  req_t req_q;
  rsp_t rsp_q;
  logic rsp_valid_q;
  logic [GA-1:0] clr_q;

  // Grid RAM port.
  logic g_we;
  logic [GA-1:0] g_addr;
  logic [2:0] g_wdata, g_rdata;
  // Stack RAM port.
  logic s_we;
  logic [SA-1:0] s_addr;
  logic [XC+YC-1:0] s_wdata, s_rdata;

  gdfs_ram #(.Width(3), .Depth(GD)) u_grid (
    .clk_i, .we_i(g_we), .addr_i(g_addr), .wdata_i(g_wdata), .rdata_o(g_rdata)
  );
  gdfs_ram #(.Width(XC + YC), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata)
  );

  // Columns and rows in use, clipped to the array size.
  logic [8:0] uw, uh;
  assign uw = (9'(width_q) < 9'(MAX_WIDTH)) ? 9'(width_q) : 9'(MAX_WIDTH);
  assign uh = (9'(height_q) < 9'(MAX_HEIGHT)) ? 9'(height_q) : 9'(MAX_HEIGHT);

  function automatic logic [GA-1:0] idx(input logic [XC-1:0] x, input logic [YC-1:0] y);
    idx = GA'(x[XW-1:0]) * GA'(MAX_HEIGHT) + GA'(y[YW-1:0]);
  endfunction

  logic cur_in, nb_in, req_in, full;
  assign cur_in = (9'(cx_q) < uw) && (9'(cy_q) < uh);
  assign nb_in  = (9'(nx_q) < uw) && (9'(ny_q) < uh);
  assign req_in = (9'(req_q.pos_x) < uw) && (9'(req_q.pos_y) < uh);
  assign full   = (cnt_q >= CW'(STACK_DEPTH));

  // Neighbour candidate from the popped cell: left, up, right, down.
  logic [XC-1:0] cand_x;
  logic [YC-1:0] cand_y;
  logic cand_ok;
  always_comb begin
    cand_x = cx_q;
    cand_y = cy_q;
    cand_ok = 1'b1;
    case (nb_q)
      2'd0: begin cand_x = cx_q - XC'(1); cand_ok = (cx_q != '0); end
      2'd1: begin cand_y = cy_q - YC'(1); cand_ok = (cy_q != '0); end
      2'd2: cand_x = cx_q + XC'(1);
      default: cand_y = cy_q + YC'(1);
    endcase
  end

  // Memory address and write control follow the state.
  always_comb begin
    g_we = 1'b0; g_addr = idx(nx_q, ny_q); g_wdata = CODE_QUEUED;
    s_we = 1'b0; s_addr = SA'(cnt_q); s_wdata = {nx_q, ny_q};
    case (state_q)
      S_CLEAR: begin g_we = 1'b1; g_addr = clr_q; g_wdata = CODE_EMPTY; end
      S_RD: begin
        g_addr = idx(XC'(req_q.pos_x), YC'(req_q.pos_y));
        g_we = (req_q.req_type == REQ_WRITE) && req_in;
        g_wdata = (req_q.cell_code > CODE_VISITED) ? CODE_WALL : req_q.cell_code;
      end
      S_SCAN: g_addr = idx(cx_q, cy_q);
      S_POP: s_addr = SA'(cnt_q - CW'(1));
      S_POPW: g_addr = idx(XC'(s_rdata[XC+YC-1:YC]), s_rdata[YC-1:0]);
      S_CUR: begin
        g_addr = idx(cx_q, cy_q);
        g_we = cur_in && (g_rdata != CODE_START) && (g_rdata != CODE_END);
        g_wdata = CODE_VISITED;
      end
      S_NBCHK: g_we = (g_rdata == CODE_EMPTY);
      S_PUSH: s_we = !full;
      default: ;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  // Sequencer and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      width_q <= 7'd64;
      height_q <= 7'd64;
      cnt_q <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q <= '0;
      req_q <= '0;
      cx_q <= '0; cy_q <= '0; nx_q <= '0; ny_q <= '0; nb_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + GA'(1);
          if (clr_q == GA'(GD - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (req_valid_i && req_ready_o) begin
          req_q <= req_i;
          // A step on an empty stack finishes at once.
          rsp_q <= '{read_code: '0,
                     finished: (req_i.req_type == REQ_STEP) && (cnt_q == '0),
                     found_end: 1'b0, popped_x: '0, popped_y: '0, overflow: 1'b0};
          cx_q <= '0; cy_q <= '0;
          case (req_i.req_type)
            REQ_INIT: begin
              cnt_q <= '0;
              state_q <= (uw == 9'd0 || uh == 9'd0) ? S_DONE : S_SCAN;
            end
            REQ_STEP: begin
              state_q <= (cnt_q == '0) ? S_DONE : S_POP;
            end
            default: state_q <= S_RD;
          endcase
        end
        S_RD: state_q <= S_RDW;
        S_RDW: begin
          if (req_q.req_type == REQ_READ) rsp_q.read_code <= req_in ? g_rdata : CODE_WALL;
          state_q <= S_DONE;
        end
        S_SCAN: state_q <= S_SCANW;
        S_SCANW: begin
          if (g_rdata == CODE_START) begin
            nx_q <= cx_q; ny_q <= cy_q;
            state_q <= S_PUSH;
          end else if (9'(cy_q) + 9'd1 < uh) begin
            cy_q <= cy_q + YC'(1); state_q <= S_SCAN;
          end else if (9'(cx_q) + 9'd1 < uw) begin
            cy_q <= '0; cx_q <= cx_q + XC'(1); state_q <= S_SCAN;
          end else state_q <= S_DONE;
        end
        S_POP: begin
          cnt_q <= cnt_q - CW'(1);
          state_q <= S_POPW;
        end
        S_POPW: begin
          cx_q <= s_rdata[XC+YC-1:YC];
          cy_q <= s_rdata[YC-1:0];
          rsp_q.popped_x <= 6'(s_rdata[XC+YC-1:YC]);
          rsp_q.popped_y <= 6'(s_rdata[YC-1:0]);
          state_q <= S_CUR;
        end
        S_CUR: begin
          nb_q <= '0;
          if (cur_in && g_rdata == CODE_END) begin
            rsp_q.finished <= 1'b1; rsp_q.found_end <= 1'b1;
            state_q <= S_DONE;
          end else state_q <= S_NB;
        end
        S_NB: begin
          if (!cand_ok) begin
            nb_q <= nb_q + 2'd1;
            state_q <= (nb_q == 2'd3) ? S_DONE : S_NB;
          end else begin
            nx_q <= cand_x; ny_q <= cand_y;
            state_q <= S_NBW;
          end
        end
        S_NBW: begin
          if (nb_in) state_q <= S_NBCHK;
          else begin
            nb_q <= nb_q + 2'd1;
            state_q <= (nb_q == 2'd3) ? S_DONE : S_NB;
          end
        end
        S_NBCHK: begin
          if (g_rdata == CODE_EMPTY || g_rdata == CODE_END) state_q <= S_PUSH;
          else begin
            nb_q <= nb_q + 2'd1;
            state_q <= (nb_q == 2'd3) ? S_DONE : S_NB;
          end
        end
        S_PUSH: begin
          if (full) rsp_q.overflow <= 1'b1;
          else cnt_q <= cnt_q + CW'(1);
          if (req_q.req_type == REQ_INIT || nb_q == 2'd3) state_q <= S_DONE;
          else begin
            nb_q <= nb_q + 2'd1; state_q <= S_NB;
          end
        end
        S_DONE: begin
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_we |-> !full) else $error("push into full stack");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o) else $error("two items in flight");
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_DONE) else $error("stray result");

endmodule
`default_nettype wire

FILE: test/tb_grid_depth_first_search_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_depth_first_search_step
// Self-checking testbench for the grid depth-first search step engine.
// A behavioral copy of the grid, the coordinate stack and the size registers
// predicts every response. Directed tests cover cell access, small searches,
// a missing start cell and a grid that shrinks during a search. Random mazes
// and noise follow, with bursty request traffic, a stalling receiver and one
// long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_grid_depth_first_search_step;
  import gdfs_pkg::*;

  localparam int GRID_W       = 64;
  localparam int GRID_H       = 64;
  localparam int STK_DEPTH    = 4096;
  localparam int IDLE_LIMIT   = 40000;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 400;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       req_valid_i = 1'b0;
  logic       req_ready_o;
  req_t       req_i       = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 1'b0;
  rsp_t       rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i  = '0;

  grid_depth_first_search_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the engine state.
  logic [2:0] grid_model [GRID_W*GRID_H];
  int         stk_x [STK_DEPTH];
  int         stk_y [STK_DEPTH];
  int         stk_count;
  logic [6:0] cols_cfg = 7'd64;
  logic [6:0] rows_cfg = 7'd64;

  rsp_t rsp_expect [$];
  int   n_items, n_results, n_errors, n_searches, n_overflows;
  int   burst_left;
  int   hold_seq, hold_seen, hold_left;
  int   pat_cnt;
  int   idle_cnt;

  function automatic int used_cols();
    return (cols_cfg < GRID_W) ? int'(cols_cfg) : GRID_W;
  endfunction

  function automatic int used_rows();
    return (rows_cfg < GRID_H) ? int'(rows_cfg) : GRID_H;
  endfunction

  function automatic bit in_area(int x, int y);
    return x < used_cols() && y < used_rows();
  endfunction

  // Returns 1 when the stack is full and the coordinate is dropped.
  function automatic bit push_point(int x, int y);
    if (stk_count >= STK_DEPTH) return 1'b1;
    stk_x[stk_count] = x;
    stk_y[stk_count] = y;
    stk_count++;
    return 1'b0;
  endfunction

  // Looks at one neighbour: empty ones get queued, end cells go on unmarked.
  function automatic bit probe_neighbour(int x, int y);
    int idx;
    if (!in_area(x, y)) return 1'b0;
    idx = x * GRID_H + y;
    if (grid_model[idx] == CODE_EMPTY) begin
      grid_model[idx] = CODE_QUEUED;
      return push_point(x, y);
    end
    if (grid_model[idx] == CODE_END) return push_point(x, y);
    return 1'b0;
  endfunction

  // Computes the response of one request and updates the shadow state.
  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int x, y;
    bit done, ovf;
    o = '0;
    case (r.req_type)
      REQ_WRITE: begin
        if (in_area(r.pos_x, r.pos_y))
          grid_model[r.pos_x * GRID_H + r.pos_y] =
            (r.cell_code > CODE_VISITED) ? CODE_WALL : r.cell_code;
      end
      REQ_READ: begin
        o.read_code = in_area(r.pos_x, r.pos_y) ?
                      grid_model[r.pos_x * GRID_H + r.pos_y] : CODE_WALL;
      end
      REQ_INIT: begin
        done = 1'b0;
        stk_count = 0;
        for (x = 0; x < used_cols() && !done; x++) begin
          for (y = 0; y < used_rows() && !done; y++) begin
            if (grid_model[x * GRID_H + y] == CODE_START) begin
              o.overflow = push_point(x, y);
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        if (stk_count == 0) begin
          o.finished = 1'b1;
        end else begin
          stk_count--;
          x = stk_x[stk_count];
          y = stk_y[stk_count];
          o.popped_x = x[5:0];
          o.popped_y = y[5:0];
          if (in_area(x, y) && grid_model[x * GRID_H + y] == CODE_END) begin
            o.finished  = 1'b1;
            o.found_end = 1'b1;
          end else begin
            ovf = 1'b0;
            if (in_area(x, y) && grid_model[x * GRID_H + y] != CODE_START)
              grid_model[x * GRID_H + y] = CODE_VISITED;
            if (x > 0 && probe_neighbour(x - 1, y)) ovf = 1'b1;
            if (y > 0 && probe_neighbour(x, y - 1)) ovf = 1'b1;
            if (probe_neighbour(x + 1, y)) ovf = 1'b1;
            if (probe_neighbour(x, y + 1)) ovf = 1'b1;
            o.overflow = ovf;
          end
        end
      end
    endcase
    return o;
  endfunction

  // Offers one item and records its predicted response once accepted.
  // Valid stays high afterwards unless a gap follows; quiet_until_drained
  // lowers it before any wait.
  task automatic send_req(input req_t r, output rsp_t pred);
    int gap;
    req_i       <= r;
    req_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    pred = predict_rsp(r);
    rsp_expect.push_back(pred);
    n_items++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_fields(input logic [1:0] kind, input int x, input int y,
                             input int code, output rsp_t pred);
    req_t r;
    r.req_type  = kind;
    r.pos_x     = x[5:0];
    r.pos_y     = y[5:0];
    r.cell_code = code[2:0];
    send_req(r, pred);
  endtask

  // Stops offering items and waits until every response has come back.
  task automatic quiet_until_drained();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_expect.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one size register while the engine is idle.
  task automatic write_cfg(input logic idx, input logic [6:0] val);
    quiet_until_drained();
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_WIDTH) cols_cfg = val;
    else rows_cfg = val;
    @(posedge clk_i);
  endtask

  task automatic set_size(input logic [6:0] w, input logic [6:0] h);
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
  endtask

  // Issues search steps until the predicted response says finished.
  task automatic step_until_done(input int max_steps);
    rsp_t p;
    int n;
    n = 0;
    p = '0;
    while (!p.finished && n < max_steps) begin
      send_fields(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63), 0, p);
      n++;
    end
    if (p.finished) n_searches++;
  endtask

  task automatic test_cell_access();
    rsp_t p;
    send_fields(REQ_WRITE, 0, 0, CODE_WALL, p);
    send_fields(REQ_WRITE, 63, 63, CODE_VISITED, p);
    send_fields(REQ_WRITE, 63, 0, 6, p);
    send_fields(REQ_WRITE, 0, 63, 7, p);
    send_fields(REQ_READ, 0, 0, 7, p);
    send_fields(REQ_READ, 63, 63, 0, p);
    send_fields(REQ_READ, 63, 0, 0, p);
    send_fields(REQ_READ, 0, 63, 0, p);
    // Outside the grid in use: writes are dropped, reads return wall.
    set_size(7'd4, 7'd4);
    send_fields(REQ_WRITE, 5, 1, CODE_END, p);
    send_fields(REQ_READ, 5, 1, 0, p);
    send_fields(REQ_READ, 1, 63, 0, p);
  endtask

  task automatic test_small_search();
    rsp_t p;
    set_size(7'd3, 7'd3);
    for (int x = 0; x < 3; x++)
      for (int y = 0; y < 3; y++)
        send_fields(REQ_WRITE, x, y, CODE_EMPTY, p);
    send_fields(REQ_WRITE, 1, 1, CODE_START, p);
    send_fields(REQ_WRITE, 2, 2, CODE_END, p);
    send_fields(REQ_WRITE, 1, 2, CODE_WALL, p);
    send_fields(REQ_INIT, 0, 0, 0, p);
    step_until_done(30);
    // A step on the emptied stack also reports finished.
    send_fields(REQ_STEP, 0, 0, 0, p);
    send_fields(REQ_READ, 0, 0, 0, p);
  endtask

  task automatic test_no_start();
    rsp_t p;
    set_size(7'd0, 7'd64);
    send_fields(REQ_READ, 0, 0, 0, p);
    send_fields(REQ_INIT, 0, 0, 0, p);
    send_fields(REQ_STEP, 0, 0, 0, p);
    set_size(7'd127, 7'd1);
    send_fields(REQ_INIT, 0, 0, 0, p);
    send_fields(REQ_STEP, 0, 0, 0, p);
  endtask

  task automatic test_shrink_mid_search();
    rsp_t p;
    set_size(7'd8, 7'd8);
    for (int x = 0; x < 8; x++)
      for (int y = 0; y < 8; y++)
        send_fields(REQ_WRITE, x, y, (x == 7 && y == 7) ? CODE_START : CODE_EMPTY, p);
    send_fields(REQ_INIT, 0, 0, 0, p);
    send_fields(REQ_STEP, 0, 0, 0, p);
    send_fields(REQ_STEP, 0, 0, 0, p);
    // Popped coordinates now lie outside the grid and count as walls.
    set_size(7'd4, 7'd5);
    step_until_done(80);
  endtask

  task automatic send_noise();
    req_t r;
    rsp_t p;
    logic [31:0] rnd;
    rnd = $urandom;
    r = rnd[$bits(req_t)-1:0];
    send_req(r, p);
  endtask

  task automatic test_random_mazes();
    rsp_t p;
    int target, w, h, sel, code;
    target = n_items + RANDOM_ITEMS;
    while (n_items < target) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        w = ($urandom_range(0, 1) == 0) ? 0 : 127;
        h = $urandom_range(0, 127);
      end else if (sel == 1) begin
        w = 64;
        h = 64;
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      set_size(w[6:0], h[6:0]);
      if (sel == 1) begin
        for (int i = 0; i < 30; i++)
          send_fields(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 1), p);
      end else begin
        for (int x = 0; x < w && x < 8; x++)
          for (int y = 0; y < h && y < 8; y++) begin
            code = ($urandom_range(0, 9) < 6) ? CODE_EMPTY : CODE_WALL;
            if ($urandom_range(0, 9) == 0) send_noise();
            send_fields(REQ_WRITE, x, y, code, p);
          end
      end
      if ($urandom_range(0, 7) != 0)
        send_fields(REQ_WRITE, $urandom_range(0, 7), $urandom_range(0, 7), CODE_START, p);
      if ($urandom_range(0, 3) != 0)
        send_fields(REQ_WRITE, $urandom_range(0, 7), $urandom_range(0, 7), CODE_END, p);
      send_fields(REQ_INIT, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 7), p);
      for (int s = 0; s < 120 && !p.finished; s++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        if (s == 3 && $urandom_range(0, 5) == 0)
          set_size(7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)));
        send_fields(REQ_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 7), p);
      end
      if (p.finished) n_searches++;
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    rsp_t p;
    set_size(7'd6, 7'd6);
    hold_seq++;
    for (int i = 0; i < 40; i++)
      send_fields(2'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 7), p);
  endtask

  // Receiver: a shifting stall pattern plus the requested long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
      pat_cnt     <= 0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      rsp_ready_i <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      rsp_ready_i <= 1'b0;
    end else begin
      pat_cnt <= pat_cnt + 1;
      case (pat_cnt[10:8])
        3'd0, 3'd4: rsp_ready_i <= 1'b1;
        3'd1:       rsp_ready_i <= 1'($urandom_range(0, 1));
        3'd2:       rsp_ready_i <= ($urandom_range(0, 3) == 0);
        3'd3:       rsp_ready_i <= (pat_cnt % 3 == 0);
        default:    rsp_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      n_errors++;
    end
  endtask

  // Response checker: each accepted item is compared with the oldest one expected.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      n_results++;
      if (rsp_expect.size() == 0) begin
        $error("response with nothing expected");
        n_errors++;
      end else begin
        e = rsp_expect.pop_front();
        check_field("read_code", e.read_code, rsp_o.read_code);
        check_field("finished", e.finished, rsp_o.finished);
        check_field("found_end", e.found_end, rsp_o.found_end);
        check_field("popped_x", e.popped_x, rsp_o.popped_x);
        check_field("popped_y", e.popped_y, rsp_o.popped_y);
        check_field("overflow", e.overflow, rsp_o.overflow);
        if (e.overflow) n_overflows++;
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb_grid_depth_first_search_step: FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < GRID_W*GRID_H; i++) grid_model[i] = CODE_EMPTY;
    stk_count   = 0;
    n_items     = 0;
    n_results   = 0;
    n_errors    = 0;
    n_searches  = 0;
    n_overflows = 0;
    burst_left  = 0;
    hold_seq    = 0;
    idle_cnt    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_cell_access();
    test_small_search();
    test_no_start();
    test_shrink_mid_search();
    test_backpressure();
    test_random_mazes();
    quiet_until_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests and %0d responses, %0d searches finished,",
             n_items, n_results, n_searches);
    $display("grid sizes from none to clamped full, %0d overflow responses.", n_overflows);
    if (n_errors == 0 && rsp_expect.size() == 0) begin
      $display("tb_grid_depth_first_search_step: PASS");
    end else begin
      $display("tb_grid_depth_first_search_step: FAIL");
    end
    $finish;
  end

endmodule

FILE: grid_depth_first_search_step.f
sv/gdfs_pkg.sv
sv/gdfs_ram.sv
sv/grid_depth_first_search_step.sv
test/tb_grid_depth_first_search_step.sv
